[design/rag_pkg.sv]
// shared types and constants for the rational accumulator
`timescale 1ns / 1ps
package rag_pkg;
   localparam int WIDTH = 32;
   localparam int DW = 64;
   localparam int DCW = 7;

   localparam logic [2:0] OP_LOAD = 3'd0;
   localparam logic [2:0] OP_ADD  = 3'd1;
   localparam logic [2:0] OP_SUB  = 3'd2;
   localparam logic [2:0] OP_MUL  = 3'd3;
   localparam logic [2:0] OP_DIV  = 3'd4;
   localparam logic [2:0] OP_INC  = 3'd5;
   localparam logic [2:0] OP_DEC  = 3'd6;
   localparam logic [2:0] OP_CMP  = 3'd7;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_OVF  = 2'd2;

   typedef struct packed {
      logic start;
      logic [DW-1:0] dividend;
      logic [DW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [DW-1:0] quotient;
      logic [DW-1:0] remainder;
   } div_rsp_type;
endpackage

[design/rag_divider.sv]
// shared radix-2 restoring divider, 64 bits, one quotient bit per cycle
`timescale 1ns / 1ps
module rag_divider (
   input  logic clock,
   input  logic reset,
   input  rag_pkg::div_req_type req,
   output rag_pkg::div_rsp_type rsp
);
   import rag_pkg::*;

   logic busy_ff, busy_in;
   logic [DCW-1:0] count_ff, count_in;
   logic [DW-1:0] quo_ff, quo_in, rem_ff, rem_in, dvs_ff, dvs_in;
   logic done_ff, done_in;
   logic [DW:0] trial;

   always_comb begin
      busy_in = busy_ff;
      count_in = count_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      done_in = 1'b0;
      trial = {rem_ff, quo_ff[DW-1]} - {1'b0, dvs_ff};
      if (req.start) begin
         busy_in = 1'b1;
         count_in = '0;
         quo_in = req.dividend;
         rem_in = '0;
         dvs_in = req.divisor;
      end else if (busy_ff) begin
         if (trial[DW]) begin
            rem_in = {rem_ff[DW-2:0], quo_ff[DW-1]};
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end else begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == DCW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quotient = quo_ff;
   assign rsp.remainder = rem_ff;
endmodule

[design/rational_accumulator_gcd_reduce_top.sv]
// top level of the rational accumulator with gcd reduction
`timescale 1ns / 1ps
// keeps one reduced fraction and applies one operation per request word
// req channel: tdata carries operation, operand numerator and denominator;
//   one word is taken only while the block is idle
// rsp channel: one word per request with the reduced accumulator, the
//   compare flags and a status code
// cross products are formed on one 32x32 multiplier in successive steps;
//   the reduction then runs the euclidean gcd on one shared 64-bit serial
//   divider, one remainder step per division, followed by two exact
//   divisions, so the time per item grows with the number of gcd steps
// compare, zero denominator or divisor errors and zero results skip the divider
// reset: accumulator becomes 0/1, no response pending
// a stalled rsp holds the word; the next request is refused until it is
//   taken, the accumulator is never lost
// errors (zero denominator or divisor, result out of range) leave the
//   accumulator unchanged and show status
module rational_accumulator_gcd_reduce_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // operation[2:0], operand_num[34:3], operand_den[66:35], zero fill to 72
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // result_num[31:0], result_den[62:32], is_less[63], is_equal[64],
   // is_greater[65], status[67:66], zero fill to 72
   output logic [71:0] rsp_tdata
);
   import rag_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_COMB = 3'd2;
   localparam logic [2:0] S_GCD  = 3'd3;
   localparam logic [2:0] S_DIVN = 3'd4;
   localparam logic [2:0] S_DIVD = 3'd5;
   localparam logic [2:0] S_FIN  = 3'd6;
   localparam logic [2:0] S_OUT  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [1:0] mstep_ff, mstep_in;
   logic signed [WIDTH-1:0] accn_ff, accn_in;
   logic [WIDTH-1:0] accd_ff, accd_in;
   logic [2:0] op_ff, op_in;
   logic opneg_ff, opneg_in;
   logic [31:0] onm_ff, onm_in, odm_ff, odm_in;
   logic [DW-1:0] pa_ff, pa_in, pb_ff, pb_in;
   logic [DW-1:0] n_ff, n_in, d_ff, d_in;
   logic [DW-1:0] ga_ff, ga_in, gb_ff, gb_in;
   logic neg_ff, neg_in;
   logic started_ff, started_in;
   logic [31:0] rnum_ff, rnum_in;
   logic [30:0] rden_ff, rden_in;
   logic lt_ff, lt_in, eq_ff, eq_in, gt_ff, gt_in;
   logic [1:0] status_ff, status_in;

   div_req_type dreq;
   div_rsp_type drsp;

   rag_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   logic [2:0] in_op;
   logic signed [31:0] in_num, in_den;
   logic [31:0] in_nm, in_dm, anm, adm;
   logic accneg;
   logic [31:0] ma, mb;
   logic [63:0] prod;
   logic [DW-1:0] lim;
   logic bneg;
   logic rneg;

   assign in_op  = req_tdata[2:0];
   assign in_num = req_tdata[34:3];
   assign in_den = req_tdata[66:35];
   assign in_nm  = in_num[31] ? 32'(-in_num) : in_num;
   assign in_dm  = in_den[31] ? 32'(-in_den) : in_den;
   assign accneg = accn_ff[WIDTH-1];
   assign anm    = accneg ? 32'(-32'(signed'(accn_ff))) : 32'(accn_ff);
   assign adm    = 32'(accd_ff);
   assign prod   = {32'd0, ma} * {32'd0, mb};
   assign lim    = DW'(1) << (WIDTH - 1);
   assign bneg   = (op_ff == OP_SUB) ? !opneg_ff : opneg_ff;
   // operand side of a compare is negative only when its product is nonzero
   assign rneg   = opneg_ff && pb_ff != '0;

   // multiplier operand select: step 0 numerator-side, step 1 denominator-side,
   // step 2 common denominator for add and subtract
   always_comb begin
      ma = anm;
      mb = odm_ff;
      unique case (op_ff)
         OP_ADD, OP_SUB, OP_CMP: begin
            if (mstep_ff == 2'd0) begin
               ma = anm;
               mb = odm_ff;
            end else if (mstep_ff == 2'd1) begin
               ma = onm_ff;
               mb = adm;
            end else begin
               ma = adm;
               mb = odm_ff;
            end
         end
         OP_MUL: begin
            ma = (mstep_ff == 2'd0) ? anm : adm;
            mb = (mstep_ff == 2'd0) ? onm_ff : odm_ff;
         end
         OP_DIV: begin
            ma = (mstep_ff == 2'd0) ? anm : adm;
            mb = (mstep_ff == 2'd0) ? odm_ff : onm_ff;
         end
         default: begin
            ma = anm;
            mb = odm_ff;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      mstep_in = mstep_ff;
      accn_in = accn_ff;
      accd_in = accd_ff;
      op_in = op_ff;
      opneg_in = opneg_ff;
      onm_in = onm_ff;
      odm_in = odm_ff;
      pa_in = pa_ff;
      pb_in = pb_ff;
      n_in = n_ff;
      d_in = d_ff;
      ga_in = ga_ff;
      gb_in = gb_ff;
      neg_in = neg_ff;
      started_in = 1'b0;
      rnum_in = rnum_ff;
      rden_in = rden_ff;
      lt_in = lt_ff;
      eq_in = eq_ff;
      gt_in = gt_ff;
      status_in = status_ff;
      dreq.start = 1'b0;
      dreq.dividend = ga_ff;
      dreq.divisor = gb_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in = in_op;
               opneg_in = in_num[31] != in_den[31];
               onm_in = in_nm;
               odm_in = in_dm;
               mstep_in = 2'd0;
               lt_in = 1'b0;
               eq_in = 1'b0;
               gt_in = 1'b0;
               status_in = ST_OK;
               if (in_op != OP_INC && in_op != OP_DEC && in_dm == 32'd0) begin
                  status_in = ST_ZERO;
                  state_in = S_OUT;
               end else if (in_op == OP_DIV && in_nm == 32'd0) begin
                  status_in = ST_ZERO;
                  state_in = S_OUT;
               end else if (in_op == OP_LOAD) begin
                  neg_in = in_num[31] != in_den[31];
                  n_in = DW'(in_nm);
                  d_in = DW'(in_dm);
                  state_in = S_COMB;
               end else if (in_op == OP_INC || in_op == OP_DEC) begin
                  state_in = S_COMB;
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            if (mstep_ff == 2'd0) begin
               pa_in = prod;
               mstep_in = 2'd1;
            end else if (mstep_ff == 2'd1) begin
               pb_in = prod;
               if (op_ff == OP_ADD || op_ff == OP_SUB) begin
                  mstep_in = 2'd2;
               end else begin
                  state_in = S_COMB;
               end
            end else begin
               d_in = prod;
               state_in = S_COMB;
            end
         end
         S_COMB: begin
            unique case (op_ff)
               OP_LOAD: begin
               end
               OP_ADD, OP_SUB: begin
                  if (accneg == bneg) begin
                     n_in = pa_ff + pb_ff;
                     neg_in = accneg;
                  end else if (pa_ff >= pb_ff) begin
                     n_in = pa_ff - pb_ff;
                     neg_in = accneg;
                  end else begin
                     n_in = pb_ff - pa_ff;
                     neg_in = bneg;
                  end
               end
               OP_MUL, OP_DIV: begin
                  n_in = pa_ff;
                  d_in = pb_ff;
                  neg_in = accneg != opneg_ff;
               end
               OP_INC, OP_DEC: begin
                  if (op_ff == OP_INC) begin
                     if (!accneg) begin
                        n_in = DW'(anm) + DW'(adm);
                        neg_in = 1'b0;
                     end else if (anm > adm) begin
                        n_in = DW'(anm - adm);
                        neg_in = 1'b1;
                     end else begin
                        n_in = DW'(adm - anm);
                        neg_in = 1'b0;
                     end
                  end else begin
                     if (accneg) begin
                        n_in = DW'(anm) + DW'(adm);
                        neg_in = 1'b1;
                     end else if (adm > anm) begin
                        n_in = DW'(adm - anm);
                        neg_in = 1'b1;
                     end else begin
                        n_in = DW'(anm - adm);
                        neg_in = 1'b0;
                     end
                  end
                  d_in = DW'(adm);
               end
               default: begin
                  // signed compare of the two cross products
                  if (accneg != rneg) begin
                     lt_in = accneg;
                     gt_in = rneg;
                  end else if (accneg) begin
                     lt_in = pa_ff > pb_ff;
                     gt_in = pa_ff < pb_ff;
                  end else begin
                     lt_in = pa_ff < pb_ff;
                     gt_in = pa_ff > pb_ff;
                  end
                  eq_in = accneg == rneg && pa_ff == pb_ff;
               end
            endcase
            if (op_ff == OP_CMP) begin
               state_in = S_OUT;
            end else begin
               ga_in = n_in;
               gb_in = d_in;
               started_in = 1'b1;
               state_in = (n_in == '0) ? S_FIN : S_GCD;
            end
         end
         S_GCD: begin
            // a = b, b = a mod b until b is zero
            if (gb_ff == '0) begin
               dreq.start = 1'b1;
               dreq.dividend = n_ff;
               dreq.divisor = ga_ff;
               state_in = S_DIVN;
            end else if (started_ff) begin
               dreq.start = 1'b1;
            end else if (drsp.done) begin
               ga_in = gb_ff;
               gb_in = drsp.remainder;
               started_in = 1'b1;
            end
         end
         S_DIVN: begin
            if (drsp.done) begin
               n_in = drsp.quotient;
               dreq.start = 1'b1;
               dreq.dividend = d_ff;
               dreq.divisor = ga_ff;
               state_in = S_DIVD;
            end
         end
         S_DIVD: begin
            if (drsp.done) begin
               d_in = drsp.quotient;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (n_ff == '0) begin
               accn_in = '0;
               accd_in = WIDTH'(1);
            end else if (n_ff > (neg_ff ? lim : lim - 1'b1) || d_ff > lim - 1'b1) begin
               status_in = ST_OVF;
            end else begin
               accn_in = neg_ff ? WIDTH'(-n_ff) : WIDTH'(n_ff);
               accd_in = WIDTH'(d_ff);
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      rnum_in = 32'(signed'(accn_in));
      rden_in = 31'(accd_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         accn_ff <= '0;
         accd_ff <= WIDTH'(1);
         started_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         accn_ff <= accn_in;
         accd_ff <= accd_in;
         started_ff <= started_in;
      end
      mstep_ff <= mstep_in;
      op_ff <= op_in;
      opneg_ff <= opneg_in;
      onm_ff <= onm_in;
      odm_ff <= odm_in;
      pa_ff <= pa_in;
      pb_ff <= pb_in;
      n_ff <= n_in;
      d_ff <= d_in;
      ga_ff <= ga_in;
      gb_ff <= gb_in;
      neg_ff <= neg_in;
      rnum_ff <= rnum_in;
      rden_ff <= rden_in;
      lt_ff <= lt_in;
      eq_ff <= eq_in;
      gt_ff <= gt_in;
      status_ff <= status_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata = {4'd0, status_ff, gt_ff, eq_ff, lt_ff, rden_ff, rnum_ff};
endmodule

[test/testbench.sv]
// self-checking testbench for the rational accumulator with gcd reduction
`timescale 1ns / 1ps
module testbench;
   import rag_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // operation[2:0], operand_num[34:3], operand_den[66:35], zero fill to 72
   logic [71:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // result_num[31:0], result_den[62:32], is_less[63], is_equal[64],
   // is_greater[65], status[67:66], zero fill to 72
   logic [71:0] rsp_tdata;

   // highest field first, so it lines up with rsp_tdata[67:0]
   typedef struct packed {
      logic [1:0]  status;
      logic        gt;
      logic        eq;
      logic        lt;
      logic [30:0] den;
      logic [31:0] num;
   } fraction_word_type;

   rational_accumulator_gcd_reduce_top DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // predicted accumulator
   longint acc_num;
   longint acc_den;
   fraction_word_type expected_words[$];

   int send_idle_pct;
   int recv_idle_pct;
   int hold_off_cycles;
   int mismatch_count;
   int words_checked;
   int items_sent;
   int ops_seen[8];
   int status_seen[3];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned magnitude(longint x);
      return x < 0 ? -x : x;
   endfunction

   function automatic longint unsigned euclid(longint unsigned a, longint unsigned b);
      longint unsigned t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   // applies one operation to the predicted accumulator, returns the word
   function automatic fraction_word_type apply_operation(logic [2:0] op,
                                                         logic signed [31:0] onum,
                                                         logic signed [31:0] oden);
      fraction_word_type w;
      longint on, od, l, r, s;
      longint unsigned onm, odm, anm, adm, n, d, a, b, g, lim;
      logic opneg, accneg, bneg, neg, write_back;
      on = onum;
      od = oden;
      opneg = (on < 0) != (od < 0);
      onm = magnitude(on);
      odm = magnitude(od);
      accneg = acc_num < 0;
      anm = magnitude(acc_num);
      adm = acc_den;
      w = '0;
      neg = 1'b0;
      write_back = 1'b0;
      n = 0;
      d = 1;
      lim = 64'd1 << (WIDTH - 1);
      if (op != OP_INC && op != OP_DEC && odm == 0) begin
         w.status = ST_ZERO;
      end else if (op == OP_DIV && onm == 0) begin
         w.status = ST_ZERO;
      end else begin
         write_back = 1'b1;
         case (op)
            OP_LOAD: begin
               neg = opneg; n = onm; d = odm;
            end
            OP_ADD, OP_SUB: begin
               a = anm * odm;
               b = onm * adm;
               bneg = (op == OP_SUB) ? !opneg : opneg;
               if (accneg == bneg) begin
                  n = a + b; neg = accneg;
               end else if (a >= b) begin
                  n = a - b; neg = accneg;
               end else begin
                  n = b - a; neg = bneg;
               end
               d = adm * odm;
            end
            OP_MUL: begin
               n = anm * onm; d = adm * odm; neg = accneg != opneg;
            end
            OP_DIV: begin
               n = anm * odm; d = adm * onm; neg = accneg != opneg;
            end
            OP_INC, OP_DEC: begin
               s = (op == OP_INC) ? acc_num + acc_den : acc_num - acc_den;
               n = magnitude(s); neg = s < 0; d = adm;
            end
            default: begin
               l = acc_num * longint'(odm);
               r = (opneg ? -longint'(onm) : longint'(onm)) * acc_den;
               w.lt = l < r; w.eq = l == r; w.gt = l > r;
               write_back = 1'b0;
            end
         endcase
      end
      if (write_back) begin
         if (n == 0) begin
            d = 1; neg = 1'b0;
         end else begin
            g = euclid(n, d);
            n = n / g;
            d = d / g;
         end
         if (n > (neg ? lim : lim - 1) || d > lim - 1)
            w.status = ST_OVF;
         else begin
            acc_num = neg ? -longint'(n) : longint'(n);
            acc_den = d;
         end
      end
      w.num = acc_num[31:0];
      w.den = acc_den[30:0];
      return w;
   endfunction

   // sends one request word, predicting its response when accepted
   task automatic send_word(logic [2:0] op, logic [31:0] onum, logic [31:0] oden);
      while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, oden, onum, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_words.push_back(apply_operation(op, onum, oden));
      ops_seen[op]++;
      items_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   // operand with a biased magnitude: mostly small, sometimes full range
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(9, 0))
         0, 1, 2, 3: return $urandom_range(20, 0) - 10;
         4, 5:       return $urandom_range(2000, 0) - 1000;
         6:          return $urandom_range(65535, 0) - 32768;
         7:          return {$urandom_range(1, 0) ? 32'h8000_0000 : 32'h7fff_ffff};
         default:    return $urandom();
      endcase
   endfunction

   task automatic send_random_word();
      logic [2:0]  op;
      logic [31:0] d;
      op = $urandom_range(7, 0);
      d = pick_operand();
      // zero denominators only now and then
      if (d == 0 && $urandom_range(3, 0) != 0) d = 1;
      send_word(op, pick_operand(), d);
   endtask

   // response checker
   always @(posedge clock) begin
      fraction_word_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[67:0];
         if (expected_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response word %h", got);
         end else begin
            want = expected_words.pop_front();
            words_checked++;
            if (want.status <= ST_OVF) status_seen[want.status]++;
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mismatch: expected num %0d den %0d lt%b eq%b gt%b st %0d,",
                            " got num %0d den %0d lt%b eq%b gt%b st %0d"},
                     $signed(want.num), want.den, want.lt, want.eq, want.gt, want.status,
                     $signed(got.num), got.den, got.lt, got.eq, got.gt, got.status);
            end
         end
      end
   end

   // receiver ready, with random stalls and a long hold-off on request
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_tready <= 1'b0;
      end else
         rsp_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
   end

   // extremes of every field and each special case
   task automatic test_directed();
      send_word(OP_CMP, 32'd0, 32'd1);             // reset value compares equal to zero
      send_word(OP_LOAD, 32'd6, 32'hffff_fffc);     // sign moves to numerator, reduces to -3/2
      send_word(OP_INC, 32'hffff_ffff, 32'hffff_ffff);
      send_word(OP_DEC, 32'd0, 32'd0);              // ignores operands
      send_word(OP_DEC, 32'd0, 32'd0);
      send_word(OP_ADD, 32'd1, 32'd3);
      send_word(OP_SUB, 32'd5, 32'd7);
      send_word(OP_MUL, 32'hffff_fff9, 32'd2);
      send_word(OP_DIV, 32'd3, 32'hffff_fffb);
      send_word(OP_DIV, 32'd0, 32'd5);              // zero divisor
      send_word(OP_ADD, 32'd1, 32'd0);              // zero denominator
      send_word(OP_CMP, 32'd7, 32'd0);
      send_word(OP_LOAD, 32'h8000_0000, 32'd1);     // most negative numerator
      send_word(OP_DEC, 32'd0, 32'd0);              // overflow below
      send_word(OP_LOAD, 32'h8000_0000, 32'hffff_ffff); // overflow: +2^31
      send_word(OP_LOAD, 32'h7fff_ffff, 32'd1);
      send_word(OP_INC, 32'd0, 32'd0);              // overflow above
      send_word(OP_CMP, 32'h7fff_ffff, 32'h8000_0000);
      send_word(OP_LOAD, 32'd1, 32'h7fff_ffff);
      send_word(OP_DIV, 32'd2, 32'd1);              // denominator overflow
      send_word(OP_MUL, 32'd0, 32'h8000_0000);      // zero result is stored as 0/1
      send_word(OP_CMP, 32'h8000_0000, 32'h8000_0000);
      send_word(OP_LOAD, 32'h5555_5555, 32'haaaa_aaab);
      send_word(OP_CMP, 32'hffff_ffff, 32'd1);
      wait_drained();
   endtask

   // random items in the given idling mode
   task automatic test_random(int count, int s_pct, int r_pct);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      repeat (count) send_random_word();
   endtask

   // long receiver stall while requests keep coming, then a full pause
   task automatic test_backpressure();
      hold_off_cycles = 3000;
      repeat (4) send_random_word();
      wait_drained();
   endtask

   initial begin : main
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      acc_num = 0;
      acc_den = 1;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_cycles = 0;
      mismatch_count = 0;
      words_checked = 0;
      items_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(550, 22, 72);
      test_backpressure();
      test_random(550, 72, 22);
      test_random(550, 0, 0);
      wait_drained();
      repeat (200) @(posedge clock);
      $display("sent %0d words, checked %0d; ops %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d",
         items_sent, words_checked, ops_seen[0], ops_seen[1], ops_seen[2], ops_seen[3],
         ops_seen[4], ops_seen[5], ops_seen[6], ops_seen[7]);
      $display("status ok %0d, zero %0d, overflow %0d; mismatches %0d",
         status_seen[0], status_seen[1], status_seen[2], mismatch_count);
      if (mismatch_count == 0 && expected_words.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // timeout: covers worst-case items plus receiver stalls
   initial begin : watchdog
      #1_000_000_000;
      $display("FAIL");
      $finish;
   end
endmodule

[rational_accumulator_gcd_reduce_top.f]
design/rag_pkg.sv
design/rag_divider.sv
design/rational_accumulator_gcd_reduce_top.sv
test/testbench.sv
